/* rtl/core/depth_pixel_to_world_point_unit_defines.svh */
// Assertion macros shared by the depth pixel to world point RTL.
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_UNIT_DEFINES_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled in reset
`define DPWP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpwp assertion failed");
// next-cycle implication, disabled in reset
`define DPWP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpwp assertion failed");
`else
`define DPWP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DPWP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/dpwp_pkg.sv */
// Types, constants and reset values of the depth pixel to world point unit.
package dpwp_pkg;

    // field widths
    localparam int COL_W     = 12;
    localparam int RAW_W     = 16;
    localparam int COLOR_W   = 8;
    localparam int PIDX_W    = 4;
    localparam int POSE_W    = 32;
    localparam int WORLD_W   = 32;
    localparam int DEPTH_W   = 24;   // Q8.16 depth after range check
    localparam int CENTER_W  = 16;
    localparam int INVF_W    = 24;
    localparam int STRIDE_W  = 5;
    localparam int POSE_N    = 12;
    localparam int NSTAGE    = 9;

    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // parameter defaults
    localparam int COORD_BITS_DEF = 12;
    localparam int DEPTH_BITS_DEF = 16;

    // register reset values
    localparam logic [23:0] RST_DEPTH_UNIT = 24'd16777;
    localparam logic [23:0] RST_MIN_DEPTH  = 24'd13107;
    localparam logic [23:0] RST_MAX_DEPTH  = 24'd1310720;
    localparam logic [15:0] RST_CENTER_X   = 16'd5120;
    localparam logic [15:0] RST_CENTER_Y   = 16'd3840;
    localparam logic [23:0] RST_INV_FX     = 24'd33554;
    localparam logic [23:0] RST_INV_FY     = 24'd33554;
    localparam logic [4:0]  RST_STRIDE     = 5'd4;

    localparam logic signed [31:0] POSE_ONE = 32'sh0001_0000;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_POSE  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        REG_DEPTH_UNIT = 3'd0,
        REG_MIN_DEPTH  = 3'd1,
        REG_MAX_DEPTH  = 3'd2,
        REG_CENTER_X   = 3'd3,
        REG_CENTER_Y   = 3'd4,
        REG_INV_FX     = 3'd5,
        REG_INV_FY     = 3'd6,
        REG_STRIDE     = 3'd7
    } t_reg_idx;

    // input transaction, first member in the top bits
    typedef struct packed {
        logic [3:0]          pad;
        logic [POSE_W-1:0]   pose_value;
        logic [PIDX_W-1:0]   pose_index;
        logic [COLOR_W-1:0]  blue_in;
        logic [COLOR_W-1:0]  green_in;
        logic [COLOR_W-1:0]  red_in;
        logic [RAW_W-1:0]    raw_depth;
        logic [COL_W-1:0]    row;
        logic [COL_W-1:0]    col;
    } t_s_tdata;

    typedef struct packed {
        logic gray_pixel;
        t_op  op;
    } t_s_tuser;

    typedef struct packed {
        logic [COLOR_W-1:0]  blue_out;
        logic [COLOR_W-1:0]  green_out;
        logic [COLOR_W-1:0]  red_out;
        logic [WORLD_W-1:0]  world_z;
        logic [WORLD_W-1:0]  world_y;
        logic [WORLD_W-1:0]  world_x;
    } t_m_tdata;

    localparam int S_TDATA_W = $bits(t_s_tdata);
    localparam int S_TUSER_W = $bits(t_s_tuser);
    localparam int M_TDATA_W = $bits(t_m_tdata);

endpackage

/* rtl/core/depth_pixel_to_world_point_unit.sv */
// Depth pixel to world point unit: pinhole back-projection plus rigid pose transform.
// Throughput: one transaction per cycle when m_axis is not stalled; nine pipeline registers
// with per-stage valids, bubbles collapse, so input is still accepted while a result waits
// on m_axis_tready, as long as some stage is empty.
// Reset (i_rst_n low, synchronous): pipeline emptied, config registers to defaults,
// pose store to identity rotation and zero translation.
`include "depth_pixel_to_world_point_unit_defines.svh"

module depth_pixel_to_world_point_unit #(
    parameter int COORD_BITS = dpwp_pkg::COORD_BITS_DEF,
    parameter int DEPTH_BITS = dpwp_pkg::DEPTH_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // pixel / pose-load stream in
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // col, row, raw_depth, red_in, green_in, blue_in, pose_index, pose_value, 4b zero pad
    input  logic [dpwp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // op, gray_pixel
    input  logic [dpwp_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // world point stream out
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // world_x, world_y, world_z, red_out, green_out, blue_out
    output logic [dpwp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dpwp_pkg::PADDR_W-1:0]   paddr,
    input  logic [dpwp_pkg::PDATA_W-1:0]   pwdata,
    output logic [dpwp_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    localparam int COL_W   = dpwp_pkg::COL_W;
    localparam int RAW_W   = dpwp_pkg::RAW_W;
    localparam int CLR_W   = dpwp_pkg::COLOR_W;
    localparam int NST     = dpwp_pkg::NSTAGE;

    // coordinate / depth masks, wide parameters leave the field untouched
    localparam logic [COL_W-1:0] COORD_MASK =
        (COORD_BITS >= COL_W) ? {COL_W{1'b1}} : COL_W'((1 << COORD_BITS) - 1);
    localparam logic [RAW_W-1:0] RAW_MASK =
        (DEPTH_BITS >= RAW_W) ? {RAW_W{1'b1}} : RAW_W'((1 << DEPTH_BITS) - 1);

    //------------------------------------------------------------------------
    // helpers
    //------------------------------------------------------------------------
    // one restoring step of u mod s; rem < s keeps the result in 5 bits
    function automatic logic [4:0] mod_step(input logic [4:0] rem, input logic bit_in,
                                            input logic [4:0] s);
        logic [5:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, s}) begin
            t = t - {1'b0, s};
        end
        return t[4:0];
    endfunction

    function automatic logic [31:0] sat39(input logic [38:0] x);
        logic [31:0] y;
        if (&x[38:31] || ~|x[38:31]) begin
            y = x[31:0];
        end else begin
            y = x[38] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return y;
    endfunction

    function automatic logic [31:0] sat50(input logic [49:0] x);
        logic [31:0] y;
        if (&x[49:31] || ~|x[49:31]) begin
            y = x[31:0];
        end else begin
            y = x[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return y;
    endfunction

    //------------------------------------------------------------------------
    // configuration registers (APB, zero wait states)
    //------------------------------------------------------------------------
    logic [23:0] r_depth_unit, r_min_depth, r_max_depth, r_inv_fx, r_inv_fy;
    logic [15:0] r_center_x, r_center_y;
    logic [4:0]  r_stride;
    logic        cfg_we;
    logic [4:0]  stride_eff;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_unit <= dpwp_pkg::RST_DEPTH_UNIT;
            r_min_depth  <= dpwp_pkg::RST_MIN_DEPTH;
            r_max_depth  <= dpwp_pkg::RST_MAX_DEPTH;
            r_center_x   <= dpwp_pkg::RST_CENTER_X;
            r_center_y   <= dpwp_pkg::RST_CENTER_Y;
            r_inv_fx     <= dpwp_pkg::RST_INV_FX;
            r_inv_fy     <= dpwp_pkg::RST_INV_FY;
            r_stride     <= dpwp_pkg::RST_STRIDE;
        end else if (cfg_we) begin
            unique case (dpwp_pkg::t_reg_idx'(paddr[4:2]))
                dpwp_pkg::REG_DEPTH_UNIT: r_depth_unit <= pwdata[23:0];
                dpwp_pkg::REG_MIN_DEPTH:  r_min_depth  <= pwdata[23:0];
                dpwp_pkg::REG_MAX_DEPTH:  r_max_depth  <= pwdata[23:0];
                dpwp_pkg::REG_CENTER_X:   r_center_x   <= pwdata[15:0];
                dpwp_pkg::REG_CENTER_Y:   r_center_y   <= pwdata[15:0];
                dpwp_pkg::REG_INV_FX:     r_inv_fx     <= pwdata[23:0];
                dpwp_pkg::REG_INV_FY:     r_inv_fy     <= pwdata[23:0];
                dpwp_pkg::REG_STRIDE:     r_stride     <= pwdata[4:0];
            endcase
        end
    end

    always_comb begin
        unique case (dpwp_pkg::t_reg_idx'(paddr[4:2]))
            dpwp_pkg::REG_DEPTH_UNIT: prdata = {8'd0, r_depth_unit};
            dpwp_pkg::REG_MIN_DEPTH:  prdata = {8'd0, r_min_depth};
            dpwp_pkg::REG_MAX_DEPTH:  prdata = {8'd0, r_max_depth};
            dpwp_pkg::REG_CENTER_X:   prdata = {16'd0, r_center_x};
            dpwp_pkg::REG_CENTER_Y:   prdata = {16'd0, r_center_y};
            dpwp_pkg::REG_INV_FX:     prdata = {8'd0, r_inv_fx};
            dpwp_pkg::REG_INV_FY:     prdata = {8'd0, r_inv_fy};
            dpwp_pkg::REG_STRIDE:     prdata = {27'd0, r_stride};
        endcase
    end

    // a stride of zero behaves as one
    assign stride_eff = (r_stride == 5'd0) ? 5'd1 : r_stride;

    //------------------------------------------------------------------------
    // pipeline flow control
    // Each stage loads when it is empty or its content moves on. Items that
    // emit nothing (pose loads, rejected pixels) are dropped at the output
    // register instead of occupying it.
    //------------------------------------------------------------------------
    logic [NST:1] r_vld;
    logic [NST:1] rdy;
    logic         h_emit;

    always_comb begin
        rdy[NST] = !r_vld[NST] || m_axis_tready;
        for (int k = NST - 1; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign s_axis_tready = rdy[1];
    assign m_axis_tvalid = r_vld[NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) begin
                r_vld[1] <= s_axis_tvalid;
            end
            for (int k = 2; k < NST; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (rdy[NST]) begin
                r_vld[NST] <= r_vld[NST-1] && h_emit;
            end
        end
    end

    //------------------------------------------------------------------------
    // stage 1: capture; coordinate/depth masks and the gray copy applied here
    //------------------------------------------------------------------------
    dpwp_pkg::t_s_tdata in_d;
    dpwp_pkg::t_s_tuser in_u;

    assign in_d = dpwp_pkg::t_s_tdata'(s_axis_tdata);
    assign in_u = dpwp_pkg::t_s_tuser'(s_axis_tuser);

    dpwp_pkg::t_op     r_a_op;
    logic [COL_W-1:0]  r_a_u, r_a_v;
    logic [RAW_W-1:0]  r_a_raw;
    logic [3*CLR_W-1:0] r_a_rgb;
    logic [3:0]        r_a_pidx;
    logic [31:0]       r_a_pval;

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_a_op   <= in_u.op;
            r_a_u    <= in_d.col & COORD_MASK;
            r_a_v    <= in_d.row & COORD_MASK;
            r_a_raw  <= in_d.raw_depth & RAW_MASK;
            r_a_rgb  <= in_u.gray_pixel ? {in_d.red_in, in_d.red_in, in_d.red_in}
                                        : {in_d.blue_in, in_d.green_in, in_d.red_in};
            r_a_pidx <= in_d.pose_index;
            r_a_pval <= in_d.pose_value;
        end
    end

    //------------------------------------------------------------------------
    // stage 2: depth product, centered coordinates, stride remainder bits 11..8
    //------------------------------------------------------------------------
    dpwp_pkg::t_op      r_b_op;
    logic [39:0]        r_b_dprod;
    logic signed [17:0] r_b_dux, r_b_duy;
    logic [COL_W-1:0]   r_b_u, r_b_v;
    logic [4:0]         r_b_rem_u, r_b_rem_v;
    logic [3*CLR_W-1:0] r_b_rgb;
    logic [3:0]         r_b_pidx;
    logic [31:0]        r_b_pval;
    logic [4:0]         b_rem_u, b_rem_v;

    always_comb begin
        b_rem_u = 5'd0;
        b_rem_v = 5'd0;
        for (int k = 0; k < 4; k++) begin
            b_rem_u = mod_step(b_rem_u, r_a_u[COL_W-1-k], stride_eff);
            b_rem_v = mod_step(b_rem_v, r_a_v[COL_W-1-k], stride_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_b_op    <= r_a_op;
            r_b_dprod <= 40'(r_a_raw) * 40'(r_depth_unit);
            r_b_dux   <= $signed({2'b00, r_a_u, 4'b0000}) - $signed({2'b00, r_center_x});
            r_b_duy   <= $signed({2'b00, r_a_v, 4'b0000}) - $signed({2'b00, r_center_y});
            r_b_u     <= r_a_u;
            r_b_v     <= r_a_v;
            r_b_rem_u <= b_rem_u;
            r_b_rem_v <= b_rem_v;
            r_b_rgb   <= r_a_rgb;
            r_b_pidx  <= r_a_pidx;
            r_b_pval  <= r_a_pval;
        end
    end

    //------------------------------------------------------------------------
    // stage 3: depth rounded to Q16.16, (u - cx) / fx products, remainder 7..4
    //------------------------------------------------------------------------
    dpwp_pkg::t_op      r_c_op;
    logic [31:0]        r_c_d;
    logic signed [42:0] r_c_axp, r_c_ayp;
    logic [COL_W-1:0]   r_c_u, r_c_v;
    logic [4:0]         r_c_rem_u, r_c_rem_v;
    logic [3*CLR_W-1:0] r_c_rgb;
    logic [3:0]         r_c_pidx;
    logic [31:0]        r_c_pval;
    logic [4:0]         c_rem_u, c_rem_v;

    always_comb begin
        c_rem_u = r_b_rem_u;
        c_rem_v = r_b_rem_v;
        for (int k = 0; k < 4; k++) begin
            c_rem_u = mod_step(c_rem_u, r_b_u[COL_W-5-k], stride_eff);
            c_rem_v = mod_step(c_rem_v, r_b_v[COL_W-5-k], stride_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_c_op    <= r_b_op;
            r_c_d     <= 32'((r_b_dprod + 40'd128) >> 8);
            r_c_axp   <= r_b_dux * $signed({1'b0, r_inv_fx});
            r_c_ayp   <= r_b_duy * $signed({1'b0, r_inv_fy});
            r_c_u     <= r_b_u;
            r_c_v     <= r_b_v;
            r_c_rem_u <= c_rem_u;
            r_c_rem_v <= c_rem_v;
            r_c_rgb   <= r_b_rgb;
            r_c_pidx  <= r_b_pidx;
            r_c_pval  <= r_b_pval;
        end
    end

    //------------------------------------------------------------------------
    // stage 4: range test, stride remainder 3..0, normalized coords rounded
    // (round half away from zero: add half, minus one when negative)
    //------------------------------------------------------------------------
    dpwp_pkg::t_op      r_d_op;
    logic               r_d_keep;
    logic [23:0]        r_d_d;
    logic signed [29:0] r_d_ax, r_d_ay;
    logic [3*CLR_W-1:0] r_d_rgb;
    logic [3:0]         r_d_pidx;
    logic [31:0]        r_d_pval;
    logic [4:0]         d_rem_u, d_rem_v;
    logic [42:0]        ax_sum, ay_sum;
    logic               d_in_range;

    always_comb begin
        d_rem_u = r_c_rem_u;
        d_rem_v = r_c_rem_v;
        for (int k = 0; k < 4; k++) begin
            d_rem_u = mod_step(d_rem_u, r_c_u[COL_W-9-k], stride_eff);
            d_rem_v = mod_step(d_rem_v, r_c_v[COL_W-9-k], stride_eff);
        end
    end

    assign d_in_range = (r_c_d >= {8'd0, r_min_depth}) && (r_c_d <= {8'd0, r_max_depth});
    assign ax_sum = r_c_axp + 43'd2048 - {42'd0, r_c_axp[42]};
    assign ay_sum = r_c_ayp + 43'd2048 - {42'd0, r_c_ayp[42]};

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_d_op   <= r_c_op;
            r_d_keep <= d_in_range && (d_rem_u == 5'd0) && (d_rem_v == 5'd0);
            r_d_d    <= r_c_d[23:0];   // kept pixels have d <= max_depth
            r_d_ax   <= ax_sum[41:12];
            r_d_ay   <= ay_sum[41:12];
            r_d_rgb  <= r_c_rgb;
            r_d_pidx <= r_c_pidx;
            r_d_pval <= r_c_pval;
        end
    end

    //------------------------------------------------------------------------
    // stage 5: camera x/y products a * d
    //------------------------------------------------------------------------
    dpwp_pkg::t_op      r_e_op;
    logic               r_e_keep;
    logic [23:0]        r_e_d;
    logic signed [54:0] r_e_cxp, r_e_cyp;
    logic [3*CLR_W-1:0] r_e_rgb;
    logic [3:0]         r_e_pidx;
    logic [31:0]        r_e_pval;

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r_e_op   <= r_d_op;
            r_e_keep <= r_d_keep;
            r_e_d    <= r_d_d;
            r_e_cxp  <= r_d_ax * $signed({1'b0, r_d_d});
            r_e_cyp  <= r_d_ay * $signed({1'b0, r_d_d});
            r_e_rgb  <= r_d_rgb;
            r_e_pidx <= r_d_pidx;
            r_e_pval <= r_d_pval;
        end
    end

    //------------------------------------------------------------------------
    // stage 6: camera x/y rounded by 2^16 and saturated
    //------------------------------------------------------------------------
    dpwp_pkg::t_op      r_f_op;
    logic               r_f_keep;
    logic [23:0]        r_f_d;
    logic signed [31:0] r_f_camx, r_f_camy;
    logic [3*CLR_W-1:0] r_f_rgb;
    logic [3:0]         r_f_pidx;
    logic [31:0]        r_f_pval;
    logic [54:0]        cx_sum, cy_sum;

    assign cx_sum = r_e_cxp + 55'd32768 - {54'd0, r_e_cxp[54]};
    assign cy_sum = r_e_cyp + 55'd32768 - {54'd0, r_e_cyp[54]};

    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            r_f_op   <= r_e_op;
            r_f_keep <= r_e_keep;
            r_f_d    <= r_e_d;
            r_f_camx <= $signed(sat39(cx_sum[54:16]));
            r_f_camy <= $signed(sat39(cy_sum[54:16]));
            r_f_rgb  <= r_e_rgb;
            r_f_pidx <= r_e_pidx;
            r_f_pval <= r_e_pval;
        end
    end

    //------------------------------------------------------------------------
    // pose store: 12 flops with identity reset. A pose load writes as it
    // leaves stage 6, the same edge at which pixels read the pose, so every
    // pixel sees exactly the loads that were accepted before it.
    //------------------------------------------------------------------------
    logic signed [31:0] r_pose [dpwp_pkg::POSE_N];
    logic               pose_we;

    assign pose_we = r_vld[6] && rdy[7] && (r_f_op == dpwp_pkg::OP_POSE)
                     && (r_f_pidx < 4'(dpwp_pkg::POSE_N));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < dpwp_pkg::POSE_N; k++) begin
                r_pose[k] <= ((k == 0) || (k == 4) || (k == 8)) ? dpwp_pkg::POSE_ONE
                                                                : 32'sd0;
            end
        end else if (pose_we) begin
            r_pose[r_f_pidx] <= $signed(r_f_pval);
        end
    end

    //------------------------------------------------------------------------
    // stage 7: nine rotation products, translation captured with the item
    //------------------------------------------------------------------------
    dpwp_pkg::t_op      r_g_op;
    logic               r_g_keep;
    logic signed [63:0] r_g_p [3][3];
    logic signed [31:0] r_g_t [3];
    logic [3*CLR_W-1:0] r_g_rgb;
    logic signed [31:0] cam [3];

    assign cam[0] = r_f_camx;
    assign cam[1] = r_f_camy;
    assign cam[2] = $signed({8'd0, r_f_d});

    always_ff @(posedge i_clk) begin
        if (rdy[7]) begin
            r_g_op   <= r_f_op;
            r_g_keep <= r_f_keep;
            r_g_rgb  <= r_f_rgb;
            for (int i = 0; i < 3; i++) begin
                r_g_t[i] <= r_pose[9+i];
                for (int j = 0; j < 3; j++) begin
                    r_g_p[i][j] <= r_pose[3*i+j] * cam[j];
                end
            end
        end
    end

    //------------------------------------------------------------------------
    // stage 8: each product rounded by 2^16
    //------------------------------------------------------------------------
    dpwp_pkg::t_op      r_h_op;
    logic               r_h_keep;
    logic signed [47:0] r_h_q [3][3];
    logic signed [31:0] r_h_t [3];
    logic [3*CLR_W-1:0] r_h_rgb;
    logic [63:0]        q_sum [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                q_sum[i][j] = r_g_p[i][j] + 64'd32768 - {63'd0, r_g_p[i][j][63]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[8]) begin
            r_h_op   <= r_g_op;
            r_h_keep <= r_g_keep;
            r_h_rgb  <= r_g_rgb;
            for (int i = 0; i < 3; i++) begin
                r_h_t[i] <= r_g_t[i];
                for (int j = 0; j < 3; j++) begin
                    r_h_q[i][j] <= $signed(q_sum[i][j][63:16]);
                end
            end
        end
    end

    assign h_emit = (r_h_op == dpwp_pkg::OP_PIXEL) && r_h_keep;

    //------------------------------------------------------------------------
    // stage 9: row sums plus translation, saturated; output register
    //------------------------------------------------------------------------
    logic [49:0]        acc [3];
    logic [31:0]        r_o_w [3];
    logic [3*CLR_W-1:0] r_o_rgb;
    dpwp_pkg::t_m_tdata out_d;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = {{2{r_h_q[i][0][47]}}, r_h_q[i][0]}
                   + {{2{r_h_q[i][1][47]}}, r_h_q[i][1]}
                   + {{2{r_h_q[i][2][47]}}, r_h_q[i][2]}
                   + {{18{r_h_t[i][31]}}, r_h_t[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[NST]) begin
            r_o_rgb <= r_h_rgb;
            for (int i = 0; i < 3; i++) begin
                r_o_w[i] <= sat50(acc[i]);
            end
        end
    end

    assign out_d.world_x   = r_o_w[0];
    assign out_d.world_y   = r_o_w[1];
    assign out_d.world_z   = r_o_w[2];
    assign out_d.red_out   = r_o_rgb[CLR_W-1:0];
    assign out_d.green_out = r_o_rgb[2*CLR_W-1:CLR_W];
    assign out_d.blue_out  = r_o_rgb[3*CLR_W-1:2*CLR_W];
    assign m_axis_tdata    = out_d;

    //------------------------------------------------------------------------
    // assertions
    //------------------------------------------------------------------------
    // input back-pressure only when every stage is occupied
    `DPWP_ASSERT_IMP(a_stall_only_when_full, i_clk, i_rst_n, !s_axis_tready, &r_vld)
    // an emitting item leaving stage 8 always lands in the output register
    `DPWP_ASSERT_NXT(a_emit_reaches_out, i_clk, i_rst_n, r_vld[8] && h_emit && rdy[NST],
                     m_axis_tvalid)
    // pose loads and rejected pixels never show up on the output
    `DPWP_ASSERT_NXT(a_no_spurious_out, i_clk, i_rst_n, rdy[NST] && !(r_vld[8] && h_emit),
                     !m_axis_tvalid)

endmodule
